[hdl/merge_sort_engine_unit_macros.svh]
// Assertion macros used by the checker file
`ifndef MERGE_SORT_ENGINE_UNIT_MACROS_SVH
`define MERGE_SORT_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication under an active-low reset
`define MSEU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under an active-low reset
`define MSEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mse_pkg.sv]
package mse_pkg;

    localparam int DATA_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 64;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } s_payload_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_res;
        logic                     dropped;
    } m_payload_t;

    // One slot of data moving between neighboring cells
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
    } mse_link_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_UNLOAD
    } mse_state_t;

endpackage

[hdl/mse_cell.sv]
module mse_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  mse_pkg::mse_link_t left_in,
    input  mse_pkg::mse_link_t right_hold,
    output mse_pkg::mse_link_t pass_out,
    output mse_pkg::mse_link_t hold_out
);
    import mse_pkg::*;

    logic                     full_reg, full_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic                     pass_valid_reg, pass_valid_next;
    logic signed [DATA_W-1:0] pass_data_reg, pass_data_next;

    always_comb begin
        full_next       = full_reg;
        value_next      = value_reg;
        pass_valid_next = 1'b0;
        pass_data_next  = pass_data_reg;
        if (shift_en) begin
            // take the neighbor's element, the row moves toward the output
            value_next = right_hold.data;
            full_next  = right_hold.valid;
        end else if (left_in.valid) begin
            if (!full_reg) begin
                value_next = left_in.data;
                full_next  = 1'b1;
            end else if (left_in.data < value_reg) begin
                // keep the smaller one, hand the displaced element on
                value_next      = left_in.data;
                pass_valid_next = 1'b1;
                pass_data_next  = value_reg;
            end else begin
                pass_valid_next = 1'b1;
                pass_data_next  = left_in.data;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            full_reg       <= 1'b0;
            pass_valid_reg <= 1'b0;
        end else begin
            full_reg       <= full_next;
            pass_valid_reg <= pass_valid_next;
        end
        value_reg     <= value_next;
        pass_data_reg <= pass_data_next;
    end

    assign pass_out.valid = pass_valid_reg;
    assign pass_out.data  = pass_data_reg;
    assign hold_out.valid = full_reg;
    assign hold_out.data  = value_reg;

endmodule

[hdl/merge_sort_engine_unit.sv]
// Channel  Dir  Payload (mse_pkg)                               Handshake
// s_       in   s_payload_t {value, last}                       s_valid / s_ready
// m_       out  m_payload_t {sorted_value, final_res, dropped}  m_valid / m_ready
// Load: one element per cycle, inserted into a row of MAX_ELEMENTS compare cells.
// After the closing element, a settle phase lets the insertions ripple down the row,
// then the unload phase emits one result each time the output register is free or taken.
// The row length bounds n, the number of stored elements.
// Reset (aresetn low, synchronous) empties the row and clears count and flags.
// A stalled m_ready holds the row; s_ready rises when the state returns to load, after the
// final result has entered the output register and the unload state has seen a zero count.
module merge_sort_engine_unit #(
    parameter int MAX_ELEMENTS = mse_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mse_pkg::s_payload_t s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output mse_pkg::m_payload_t m_payload
);
    import mse_pkg::*;

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    mse_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] settle_reg, settle_next;
    logic             overflow_reg, overflow_next;
    logic             m_valid_reg, m_valid_next;
    m_payload_t       m_payload_reg, m_payload_next;

    logic             s_xfer;
    logic             has_room;
    logic             shift_en;
    mse_link_t        insert_link;
    mse_link_t        pass_w [MAX_ELEMENTS];
    mse_link_t        hold_w [MAX_ELEMENTS];

    assign s_xfer   = s_valid && s_ready;
    assign has_room = count_reg < CNT_W'(MAX_ELEMENTS);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_xfer && s_payload.last) begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                if (settle_reg == CNT_W'(1)) begin
                    state_next = ST_UNLOAD;
                end
            end
            ST_UNLOAD: begin
                if (count_reg == '0) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        s_ready           = 1'b0;
        shift_en          = 1'b0;
        insert_link.valid = 1'b0;
        insert_link.data  = s_payload.value;
        count_next        = count_reg;
        settle_next       = settle_reg;
        overflow_next     = overflow_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_payload_next    = m_payload_reg;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_xfer) begin
                    if (has_room) begin
                        insert_link.valid = 1'b1;
                        count_next        = count_reg + CNT_W'(1);
                    end else begin
                        // store full: drop the element, flag the set
                        overflow_next = 1'b1;
                    end
                    if (s_payload.last) begin
                        settle_next = count_next;
                    end
                end
            end
            ST_SETTLE: begin
                settle_next = settle_reg - CNT_W'(1);
            end
            ST_UNLOAD: begin
                if (count_reg == '0) begin
                    overflow_next = 1'b0;
                end else if (!m_valid_reg || m_ready) begin
                    shift_en                    = 1'b1;
                    count_next                  = count_reg - CNT_W'(1);
                    m_valid_next                = 1'b1;
                    m_payload_next.sorted_value = hold_w[0].data;
                    m_payload_next.final_res    = (count_reg == CNT_W'(1));
                    m_payload_next.dropped      = overflow_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            settle_reg   <= '0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            settle_reg   <= settle_next;
            overflow_reg <= overflow_next;
            m_valid_reg  <= m_valid_next;
        end
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_cell
            mse_link_t left_w;
            mse_link_t right_w;
            if (gi == 0) begin : g_head
                assign left_w = insert_link;
            end else begin : g_body
                assign left_w = pass_w[gi-1];
            end
            if (gi == MAX_ELEMENTS - 1) begin : g_tail
                assign right_w = '0;
            end else begin : g_inner
                assign right_w = hold_w[gi+1];
            end
            mse_cell u_cell (
                .clk        (aclk),
                .rst_n      (aresetn),
                .shift_en   (shift_en),
                .left_in    (left_w),
                .right_hold (right_w),
                .pass_out   (pass_w[gi]),
                .hold_out   (hold_w[gi])
            );
        end
    endgenerate

endmodule

[hdl/mse_checker.sv]
`include "merge_sort_engine_unit_macros.svh"

module mse_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input mse_pkg::s_payload_t s_payload,
    input logic                m_valid,
    input logic                m_ready,
    input mse_pkg::m_payload_t m_payload
);
    import mse_pkg::*;

    `MSEU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload), "result transaction changed while stalled")
    `MSEU_ASSERT_NEXT(a_close_stops_input, aclk, aresetn, s_valid && s_ready && s_payload.last, !s_ready, "input taken right after the closing transaction")
    `MSEU_ASSERT_NOW(a_no_input_mid_set, aclk, aresetn, m_valid && !m_payload.final_res, !s_ready, "input open while a set is still being emitted")
    `MSEU_ASSERT_NEXT(a_unload_continues, aclk, aresetn, m_valid && m_ready && !m_payload.final_res, !s_ready, "input reopened before the final result")

endmodule

bind merge_sort_engine_unit mse_checker u_mse_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
